// ===== rtl/core/lcbs_pkg.sv =====
// Shared types and constants for the LED cube bit-plane scanner.
// No dependencies.
package lcbs_pkg;

    localparam int COL_W       = 16;
    localparam int LEVEL_W     = 8;
    localparam int BRIGHT_W    = 4;
    localparam int EN_W        = 4;
    localparam int COORD_W     = 2;
    localparam int KIND_W      = 2;
    localparam int FRAME_STEPS = 15;
    localparam int FRAME_W     = 4;
    localparam int MAX_PLANES  = 8;
    localparam int WEIGHT_W    = 2;

    localparam logic [BRIGHT_W-1:0] MAX_LEVEL   = 4'd15;
    localparam logic [COL_W-1:0]    ALL_COLUMNS = 16'hFFFF;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_SET   = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;

    typedef logic [WEIGHT_W-1:0] t_weight_lut [FRAME_STEPS];

    localparam t_weight_lut WEIGHT_PLANE = '{
        2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    function automatic logic [BRIGHT_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
        logic [BRIGHT_W-1:0] res;
        if (raw[LEVEL_W-1]) begin
            res = '0;
        end else if (raw > LEVEL_W'(MAX_LEVEL)) begin
            res = MAX_LEVEL;
        end else begin
            res = raw[BRIGHT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/led_cube_bitplane_scanner_unit.sv =====
// Top level of the LED cube bit-plane scanner: plane store, scan counters, handshakes.
// Depends on lcbs_pkg.

// Takes one transaction per cycle: set and clear transactions update the plane store,
// refresh ticks return one column word with its active-low layer enable. A transaction
// passes an input register and then a result register, which holds a tick's result.
// The plane store sits in flip-flops so that a clear rewrites every layer at once;
// input stalls only when a tick waits behind a stalled result.
module led_cube_bitplane_scanner_unit #(
    parameter int NUM_LAYERS = 4,
    parameter int NUM_PLANES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lcbs_pkg::KIND_W-1:0]         i_kind,
    input  logic [lcbs_pkg::COORD_W-1:0]        i_layer_sel,
    input  logic [lcbs_pkg::COORD_W-1:0]        i_row_y,
    input  logic [lcbs_pkg::COORD_W-1:0]        i_col_z,
    input  logic signed [lcbs_pkg::LEVEL_W-1:0] i_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lcbs_pkg::COL_W-1:0]          o_columns,
    output logic [lcbs_pkg::EN_W-1:0]           o_layer_enable_n
);
    import lcbs_pkg::*;

    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    logic                r_in_valid;
    t_kind               r_kind;
    logic [COORD_W-1:0]  r_lay;
    logic [COORD_W-1:0]  r_y;
    logic [COORD_W-1:0]  r_z;
    logic [LEVEL_W-1:0]  r_level;

    logic [COL_W-1:0]    r_store [NUM_LAYERS][NUM_PLANES];
    logic [COL_W-1:0]    n_store [NUM_LAYERS][NUM_PLANES];
    logic [LAYER_W-1:0]  r_scan;
    logic [LAYER_W-1:0]  n_scan;
    logic [FRAME_W-1:0]  r_frame;
    logic [FRAME_W-1:0]  n_frame;

    logic                r_out_valid;
    logic [COL_W-1:0]    r_columns;
    logic [EN_W-1:0]     r_enable_n;

    logic                out_free;
    logic                fire;
    logic                in_ready;
    logic                is_tick;
    logic [BRIGHT_W-1:0] lvl;
    logic [MAX_PLANES-1:0] lvl_ext;
    logic [COL_W-1:0]    voxel_bit;
    logic [WEIGHT_W-1:0] weight;
    logic [PLANE_W-1:0]  plane;
    logic [EN_W-1:0]     enable_n;

    assign out_free = !r_out_valid || !i_stall;
    assign is_tick  = (r_kind == KIND_TICK);
    assign fire     = r_in_valid && (!is_tick || out_free);
    assign in_ready = !r_in_valid || fire;
    assign o_stall  = !in_ready;

    assign lvl       = clamp_level(r_level);
    assign lvl_ext   = MAX_PLANES'(lvl);
    assign voxel_bit = COL_W'(1) << {r_z, r_y};
    assign weight    = WEIGHT_PLANE[r_frame];
    assign plane     = (int'(weight) > NUM_PLANES - 1) ? PLANE_W'(NUM_PLANES - 1)
                                                      : PLANE_W'(weight);

    always_comb begin
        for (int i = 0; i < EN_W; i++) begin
            enable_n[i] = (int'(r_scan) != i);
        end
    end

    always_comb begin
        n_store = r_store;
        n_scan  = r_scan;
        n_frame = r_frame;
        if (fire) begin
            unique case (r_kind)
                KIND_TICK: begin
                    n_scan  = (int'(r_scan) == NUM_LAYERS - 1) ? '0 : r_scan + 1'b1;
                    n_frame = (int'(r_frame) == FRAME_STEPS - 1) ? '0 : r_frame + 1'b1;
                end
                KIND_SET: begin
                    for (int l = 0; l < NUM_LAYERS; l++) begin
                        if (int'(r_lay) == l) begin
                            for (int p = 0; p < NUM_PLANES; p++) begin
                                n_store[l][p] = lvl_ext[p] ? (r_store[l][p] | voxel_bit)
                                                           : (r_store[l][p] & ~voxel_bit);
                            end
                        end
                    end
                end
                KIND_CLEAR: begin
                    for (int l = 0; l < NUM_LAYERS; l++) begin
                        for (int p = 0; p < NUM_PLANES; p++) begin
                            n_store[l][p] = lvl_ext[p] ? ALL_COLUMNS : '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
        if (in_ready && i_valid) begin
            r_kind  <= i_kind;
            r_lay   <= i_layer_sel;
            r_y     <= i_row_y;
            r_z     <= i_col_z;
            r_level <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LAYERS; l++) begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    r_store[l][p] <= ALL_COLUMNS;
                end
            end
            r_scan  <= '0;
            r_frame <= '0;
        end else begin
            r_store <= n_store;
            r_scan  <= n_scan;
            r_frame <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && is_tick;
        end
        if (out_free && fire && is_tick) begin
            r_columns  <= r_store[r_scan][plane];
            r_enable_n <= enable_n;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_columns        = r_columns;
    assign o_layer_enable_n = r_enable_n;

endmodule

// ===== test/led_cube_bitplane_scanner_unit_test.sv =====
// Testbench for led_cube_bitplane_scanner_unit: a queue-fed driver and a result monitor,
// both clocked, check every refresh tick against a shadow copy of the plane store.
// Depends on lcbs_pkg and the scanner RTL.
`timescale 1ns / 100ps

module led_cube_bitplane_scanner_unit_test;
    import lcbs_pkg::*;

    localparam t_kind KIND_SPARE   = 2'd3;
    localparam int    LAYERS       = 4;
    localparam int    PLANES       = 4;
    localparam int    STALL_LIMIT  = 2000;
    localparam int    DRAIN_CYCLES = 10;
    localparam int    RANDOM_ITEMS = 256;

    typedef struct packed {
        t_kind                      kind;
        logic [COORD_W-1:0]         layer;
        logic [COORD_W-1:0]         y;
        logic [COORD_W-1:0]         z;
        logic signed [LEVEL_W-1:0]  level;
    } t_cube_cmd;

    typedef struct packed {
        logic [COL_W-1:0] columns;
        logic [EN_W-1:0]  enable_n;
    } t_scan_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [KIND_W-1:0]          i_kind;
    logic [COORD_W-1:0]         i_layer_sel;
    logic [COORD_W-1:0]         i_row_y;
    logic [COORD_W-1:0]         i_col_z;
    logic signed [LEVEL_W-1:0]  i_level;
    logic                       o_valid;
    logic                       i_stall;
    logic [COL_W-1:0]           o_columns;
    logic [EN_W-1:0]            o_layer_enable_n;

    led_cube_bitplane_scanner_unit #(
        .NUM_LAYERS(LAYERS),
        .NUM_PLANES(PLANES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_layer_sel      (i_layer_sel),
        .i_row_y          (i_row_y),
        .i_col_z          (i_col_z),
        .i_level          (i_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_columns        (o_columns),
        .o_layer_enable_n (o_layer_enable_n)
    );

    t_cube_cmd  pending_cmds [$];
    t_scan_word expected_scans [$];

    logic [COL_W-1:0] shadow_planes [LAYERS][PLANES];
    logic [1:0]       shadow_layer;
    logic [3:0]       shadow_step;
    int               plane_of_step [FRAME_STEPS] =
        '{0, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3, 3, 3};

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  cmd_taken;
    int  error_count;
    int  quiet_cycles;
    int  ticks_checked;
    int  sets_seen;
    int  clears_seen;
    int  spares_seen;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic logic [BRIGHT_W-1:0] clamp_brightness(input logic signed [LEVEL_W-1:0] raw);
        logic [BRIGHT_W-1:0] res;
        if (raw < 0) begin
            res = '0;
        end else if (raw > 15) begin
            res = 4'd15;
        end else begin
            res = raw[BRIGHT_W-1:0];
        end
        return res;
    endfunction

    // Shadow store update; ticks push the expected column word.
    task automatic apply_cube_cmd(input t_cube_cmd cmd);
        logic [BRIGHT_W-1:0] bright;
        logic [COL_W-1:0]    voxel_bit;
        t_scan_word          scan;
        int                  plane;
        bright = clamp_brightness(cmd.level);
        voxel_bit = COL_W'(1) << (cmd.y + 4 * cmd.z);
        case (cmd.kind)
            KIND_TICK: begin
                plane = plane_of_step[shadow_step];
                if (plane > PLANES - 1) begin
                    plane = PLANES - 1;
                end
                scan.columns = shadow_planes[shadow_layer][plane];
                scan.enable_n = ~(EN_W'(1) << shadow_layer);
                expected_scans.push_back(scan);
                shadow_layer = shadow_layer + 2'd1;
                shadow_step = (shadow_step == FRAME_STEPS - 1) ? 4'd0 : shadow_step + 4'd1;
            end
            KIND_SET: begin
                sets_seen++;
                for (int p = 0; p < PLANES; p++) begin
                    if (bright[p]) begin
                        shadow_planes[cmd.layer][p] |= voxel_bit;
                    end else begin
                        shadow_planes[cmd.layer][p] &= ~voxel_bit;
                    end
                end
            end
            KIND_CLEAR: begin
                clears_seen++;
                for (int p = 0; p < PLANES; p++) begin
                    for (int l = 0; l < LAYERS; l++) begin
                        shadow_planes[l][p] = bright[p] ? ALL_COLUMNS : '0;
                    end
                end
            end
            default: begin
                spares_seen++;
            end
        endcase
    endtask

    function automatic t_cube_cmd make_cmd(input t_kind kind, input int layer, input int y,
                                           input int z, input int level);
        t_cube_cmd cmd;
        cmd.kind = kind;
        cmd.layer = COORD_W'(layer);
        cmd.y = COORD_W'(y);
        cmd.z = COORD_W'(z);
        cmd.level = LEVEL_W'(level);
        return cmd;
    endfunction

    function automatic t_cube_cmd random_cmd();
        t_cube_cmd cmd;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            cmd.kind = KIND_TICK;
        end else if (pick < 85) begin
            cmd.kind = KIND_SET;
        end else if (pick < 93) begin
            cmd.kind = KIND_CLEAR;
        end else begin
            cmd.kind = KIND_SPARE;
        end
        cmd.layer = COORD_W'($urandom_range(3));
        cmd.y = COORD_W'($urandom_range(3));
        cmd.z = COORD_W'($urandom_range(3));
        if ($urandom_range(99) < 60) begin
            cmd.level = LEVEL_W'($urandom_range(15));
        end else begin
            cmd.level = LEVEL_W'($urandom_range(255));
        end
        return cmd;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
        while (pending_cmds.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: new transaction or idle on the falling edge, payload held while stalled.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || cmd_taken) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    t_cube_cmd cmd;
                    cmd = pending_cmds.pop_front();
                    i_kind <= cmd.kind;
                    i_layer_sel <= cmd.layer;
                    i_row_y <= cmd.y;
                    i_col_z <= cmd.z;
                    i_level <= cmd.level;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
        cmd_taken = 1'b0;
    end

    // Monitor: results checked before the same edge's input is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_valid && !i_stall) begin
                quiet_cycles = 0;
                if (expected_scans.size() == 0) begin
                    report_mismatch($sformatf("unexpected result columns=%h enable_n=%b",
                                              o_columns, o_layer_enable_n));
                end else begin
                    t_scan_word want;
                    want = expected_scans.pop_front();
                    ticks_checked++;
                    if (o_columns !== want.columns) begin
                        report_mismatch($sformatf("columns %h, expected %h",
                                                  o_columns, want.columns));
                    end
                    if (o_layer_enable_n !== want.enable_n) begin
                        report_mismatch($sformatf("layer_enable_n %b, expected %b",
                                                  o_layer_enable_n, want.enable_n));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                quiet_cycles = 0;
                cmd_taken = 1'b1;
                apply_cube_cmd({t_kind'(i_kind), i_layer_sel, i_row_y, i_col_z, i_level});
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_TICK;
        i_layer_sel = '0;
        i_row_y = '0;
        i_col_z = '0;
        i_level = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cmd_taken = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        ticks_checked = 0;
        sets_seen = 0;
        clears_seen = 0;
        spares_seen = 0;
        shadow_layer = '0;
        shadow_step = '0;
        for (int l = 0; l < LAYERS; l++) begin
            for (int p = 0; p < PLANES; p++) begin
                shadow_planes[l][p] = ALL_COLUMNS;
            end
        end

        // Directed: reset contents, level clamping, corner voxels, unused kind, full frame.
        pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SET, 0, 0, 0, -128));
        pending_cmds.push_back(make_cmd(KIND_SET, 0, 3, 3, 127));
        pending_cmds.push_back(make_cmd(KIND_SET, 1, 1, 2, 16));
        pending_cmds.push_back(make_cmd(KIND_SET, 2, 2, 1, -1));
        pending_cmds.push_back(make_cmd(KIND_SET, 3, 3, 0, 10));
        pending_cmds.push_back(make_cmd(KIND_SET, 3, 0, 3, 5));
        pending_cmds.push_back(make_cmd(KIND_SPARE, 3, 3, 3, 0));
        repeat (14) pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, -1));
        pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 9));
        pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_phase(0, 0);
        run_phase(67, 0);
        run_phase(0, 67);
        run_phase(8, 8);

        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_scans.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_scans.size()));
        end
        $display("Covered %0d refresh ticks, %0d voxel sets, %0d clears, %0d unused-kind",
                 ticks_checked, sets_seen, clears_seen, spares_seen);
        $display("transactions, under free-running, sender-idle, stalled and mixed traffic.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
